FILE: src/uart_16550_register_model_macros.svh
// Assertion macros for the UART register model.
// Used by u16550_regfile; no other dependencies.
`ifndef UART_16550_REGISTER_MODEL_MACROS_SVH
`define UART_16550_REGISTER_MODEL_MACROS_SVH

`ifndef SYNTH
// Checked with reset held off.
`define U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define U16_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define U16_ASSERT(lbl, prop, msg)
`define U16_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/u16550_pkg.sv
// Shared types, codes and constants of the UART register model.
// No dependencies.
package u16550_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_POLL  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_RBR = 3'd0,
    REG_IER = 3'd1,
    REG_IIR = 3'd2,
    REG_LCR = 3'd3,
    REG_MCR = 3'd4,
    REG_LSR = 3'd5,
    REG_MSR = 3'd6,
    REG_SCR = 3'd7
  } reg_e;

  localparam logic [2:0] IIR_RX    = 3'h4;
  localparam logic [2:0] IIR_THRE  = 3'h2;
  localparam logic [2:0] IIR_MODEM = 3'h0;
  localparam logic [2:0] IIR_NONE  = 3'h1;

  localparam int unsigned SRC_RX    = 0;
  localparam int unsigned SRC_THRE  = 1;
  localparam int unsigned SRC_MODEM = 3;

  localparam int unsigned LCR_DLAB = 7;
  localparam int unsigned LSR_DR   = 0;
  localparam int unsigned LSR_THRE = 5;

  localparam logic [7:0] FCR_MASK    = 8'h9F;
  localparam logic [7:0] LSR_KEEP    = 8'hF0;
  localparam logic [7:0] LSR_TX_BITS = 8'h60;
  localparam logic [7:0] LSR_RX_BIT  = 8'h01;
  localparam logic [7:0] OPEN_BUS    = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       tx_ready;
    logic       rx_ready;
    logic [7:0] write_data;
    logic [3:0] reg_addr;
    logic [1:0] opcode;
  } item_t;

  typedef struct packed {
    logic       irq_line;
    logic       rx_taken;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [2:0] ident_of(input logic [3:0] pend);
    logic [2:0] id;
    if (pend[SRC_RX]) begin
      id = IIR_RX;
    end else if (pend[SRC_THRE]) begin
      id = IIR_THRE;
    end else if (pend[SRC_MODEM]) begin
      id = IIR_MODEM;
    end else begin
      id = IIR_NONE;
    end
    return id;
  endfunction

endpackage

FILE: src/u16550_regfile.sv
// Register state and per-transaction decode of the UART register model.
// Depends on u16550_pkg and uart_16550_register_model_macros.svh.
`include "uart_16550_register_model_macros.svh"

module u16550_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  u16550_pkg::item_t   item_i,
  output u16550_pkg::result_t res_o
);

  logic [7:0] ier_q, ier_d;
  logic [2:0] ident_q, ident_d;
  logic [7:0] fcr_q, fcr_d;
  logic [7:0] lcr_q, lcr_d;
  logic [5:0] mcr_q, mcr_d;
  logic [7:0] lsr_q, lsr_d;
  logic [7:0] scr_q, scr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic [3:0] pend_q, pend_d;
  logic       irq_q;
  logic [7:0] lsr_now;
  logic       dlab;

  assign dlab = lcr_q[u16550_pkg::LCR_DLAB];
  assign lsr_now = (item_i.rx_ready ? u16550_pkg::LSR_RX_BIT : 8'h00)
                 | (item_i.tx_ready ? u16550_pkg::LSR_TX_BITS : 8'h00);

  always_comb begin
    ier_d  = ier_q;
    fcr_d  = fcr_q;
    lcr_d  = lcr_q;
    mcr_d  = mcr_q;
    lsr_d  = lsr_q;
    scr_d  = scr_q;
    dll_d  = dll_q;
    dlm_d  = dlm_q;
    pend_d = pend_q;
    res_o  = '0;
    case (item_i.opcode)
      u16550_pkg::OP_READ: begin
        if (item_i.reg_addr[3]) begin
          res_o.read_data = u16550_pkg::OPEN_BUS;
        end else begin
          case (item_i.reg_addr[2:0])
            u16550_pkg::REG_RBR: begin
              if (dlab) begin
                res_o.read_data = dll_q;
              end else begin
                pend_d[u16550_pkg::SRC_RX] = 1'b0;
                res_o.read_data = item_i.rx_ready ? item_i.rx_byte : u16550_pkg::OPEN_BUS;
                res_o.rx_taken  = item_i.rx_ready;
              end
            end
            u16550_pkg::REG_IER: res_o.read_data = dlab ? dlm_q : ier_q;
            u16550_pkg::REG_IIR: res_o.read_data = {5'd0, ident_q};
            u16550_pkg::REG_LCR: res_o.read_data = lcr_q;
            u16550_pkg::REG_MCR: res_o.read_data = {2'd0, mcr_q};
            u16550_pkg::REG_LSR: begin
              res_o.read_data = lsr_now;
              lsr_d = lsr_now & u16550_pkg::LSR_KEEP;
            end
            u16550_pkg::REG_MSR: pend_d[u16550_pkg::SRC_MODEM] = 1'b0;
            u16550_pkg::REG_SCR: res_o.read_data = scr_q;
            default: res_o.read_data = u16550_pkg::OPEN_BUS;
          endcase
        end
      end
      u16550_pkg::OP_WRITE: begin
        if (!item_i.reg_addr[3]) begin
          case (item_i.reg_addr[2:0])
            u16550_pkg::REG_RBR: begin
              if (dlab) begin
                dll_d = item_i.write_data;
              end else begin
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = item_i.write_data;
                // THRE drops, then comes back if enabled
                pend_d[u16550_pkg::SRC_THRE] = ier_q[u16550_pkg::SRC_THRE];
              end
            end
            u16550_pkg::REG_IER: begin
              if (dlab) begin
                dlm_d = item_i.write_data;
              end else begin
                ier_d = item_i.write_data;
              end
            end
            u16550_pkg::REG_IIR: fcr_d = item_i.write_data & u16550_pkg::FCR_MASK;
            u16550_pkg::REG_LCR: lcr_d = item_i.write_data;
            u16550_pkg::REG_MCR: mcr_d = item_i.write_data[5:0];
            u16550_pkg::REG_SCR: scr_d = item_i.write_data;
            default: ;
          endcase
        end
      end
      u16550_pkg::OP_POLL: begin
        lsr_d = lsr_q | lsr_now;
        if (item_i.rx_ready && !lsr_q[u16550_pkg::LSR_DR]
            && ier_q[u16550_pkg::SRC_RX]) begin
          pend_d[u16550_pkg::SRC_RX] = 1'b1;
        end
        if (item_i.tx_ready && !lsr_q[u16550_pkg::LSR_THRE]
            && ier_q[u16550_pkg::SRC_THRE]) begin
          pend_d[u16550_pkg::SRC_THRE] = 1'b1;
        end
      end
      default: ;
    endcase
    // IIR is recomputed only when the pending set changes
    ident_d = (pend_d != pend_q) ? u16550_pkg::ident_of(pend_d) : ident_q;
    res_o.irq_line = |pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ier_q   <= '0;
      ident_q <= '0;
      fcr_q   <= '0;
      lcr_q   <= '0;
      mcr_q   <= '0;
      lsr_q   <= '0;
      scr_q   <= '0;
      dll_q   <= '0;
      dlm_q   <= '0;
      pend_q  <= '0;
      irq_q   <= 1'b0;
    end else if (en_i) begin
      ier_q   <= ier_d;
      ident_q <= ident_d;
      fcr_q   <= fcr_d;
      lcr_q   <= lcr_d;
      mcr_q   <= mcr_d;
      lsr_q   <= lsr_d;
      scr_q   <= scr_d;
      dll_q   <= dll_d;
      dlm_q   <= dlm_d;
      pend_q  <= pend_d;
      irq_q   <= |pend_d;
    end
  end

  `U16_ASSERT_ALWAYS(a_irq_tracks_pend, irq_q == (pend_q != 4'd0), "irq out of step with pending")
  `U16_ASSERT_ALWAYS(a_no_src2, pend_q[2] == 1'b0, "unused pending bit set")
  `U16_ASSERT(a_ident_live, (pend_q != 4'd0) |-> (ident_q != u16550_pkg::IIR_NONE), "IIR says none while pending")
  `U16_ASSERT(a_raise_enabled, en_i |=> (((pend_q & ~$past(pend_q)) & ~$past(ier_q[3:0])) == 4'd0), "source raised while disabled")
  `U16_ASSERT(a_taken_ready, (en_i && res_o.rx_taken) |-> item_i.rx_ready, "rx taken with no byte")

endmodule

FILE: src/uart_16550_register_model.sv
// Top level of the UART register model: stream ports, input and result registers.
// Depends on u16550_pkg and u16550_regfile.
// 16550-style register file driven by a stream of transactions: bus reads, bus
// writes and line-side status polls, each answered by exactly one result with
// read data, a transmit byte strobe, a receive-consumed flag and the interrupt
// line. A transaction is registered on entry, decoded combinationally against
// the register state and lands in the result register; one transaction is
// taken every cycle while the result side keeps up.
// Stalling the result side holds the result register and backs up the input.
module uart_16550_register_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // reg_addr[3:0], write_data[11:4], rx_ready[12], tx_ready[13], rx_byte[21:14], zero[23:22]
  input  logic [23:0] s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], tx_valid[8], tx_byte[16:9], rx_taken[17], irq_line[18], zero[23:19]
  output logic [23:0] m_axis_tdata_o
);

  logic                in_vld_q;
  u16550_pkg::item_t   item_q;
  logic                out_vld_q;
  u16550_pkg::result_t res_q;
  u16550_pkg::result_t res_d;
  logic                advance;
  logic                in_take;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode     <= s_axis_tuser_i;
      item_q.reg_addr   <= s_axis_tdata_i[3:0];
      item_q.write_data <= s_axis_tdata_i[11:4];
      item_q.rx_ready   <= s_axis_tdata_i[12];
      item_q.tx_ready   <= s_axis_tdata_i[13];
      item_q.rx_byte    <= s_axis_tdata_i[21:14];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  u16550_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, res_q};

endmodule
